### hw/rtl/life_generation_row_step_unit_defines.svh
// Assertion macros shared by the checker of the Life row step unit.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef LIFE_GENERATION_ROW_STEP_UNIT_DEFINES_SVH
`define LIFE_GENERATION_ROW_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define LGRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define LGRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lgrs_pkg.sv
// Package for the Life row step unit: widths, register indexes and shared types.
// Used by every module of the unit; depends on nothing.
package lgrs_pkg;

    // Field widths of the stream and configuration ports.
    localparam int ROW_BITS    = 64;
    localparam int IDX_BITS    = 10;
    localparam int OUT_TDATA_W = 80;
    localparam int COLS_W      = 7;
    localparam int ROWS_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_MAX_COLUMNS = 64;
    localparam int DEFAULT_MAX_ROWS    = 1024;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [COLS_W-1:0]    COLUMN_COUNT_RST = 7'd64;
    localparam logic [ROWS_W-1:0]    ROW_COUNT_RST    = 11'd60;

    // Result queue depth; room for two results is needed to take a row.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Per-row control shared by all cells.
    typedef struct packed {
        logic single;   // one-row frame: the row is its own frame
        logic first;    // first row of a frame: no result
        logic clear;    // frame ends with this row: state returns to dead
    } cell_ctrl_t;

    // Vertical live counts one cell hands to each neighbor.
    typedef struct packed {
        logic [1:0] sum_a;  // above + middle + below for the main result
        logic [1:0] sum_b;  // middle + incoming for the trailing result
    } col_sums_t;

    // One result item.
    typedef struct packed {
        logic [ROW_BITS-1:0] next_row;
        logic [IDX_BITS-1:0] row_index;
        logic                last_of_frame;
    } result_t;

    // Up to two results written into the queue in one cycle.
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        result_t a;
        result_t b;
    } queue_push_t;

endpackage

### hw/rtl/lgrs_cell.sv
// One column cell of the Life row step unit: holds two stored rows' bits
// and applies the B3/S23 rule. Depends on lgrs_pkg.
module lgrs_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  take,
    input  lgrs_pkg::cell_ctrl_t  ctrl,
    input  logic                  cur,
    input  lgrs_pkg::col_sums_t   left,
    input  lgrs_pkg::col_sums_t   right,
    output lgrs_pkg::col_sums_t   sums,
    output logic                  res_a,
    output logic                  res_b
);
    import lgrs_pkg::*;

    logic       upper_reg;
    logic       upper_next;
    logic       middle_reg;
    logic       middle_next;
    logic       up;
    logic       md;
    logic       cu;
    logic       top_a;
    logic       mid_a;
    logic       bot_a;
    logic [3:0] tot_a;
    logic [3:0] tot_b;

    // Cells beyond the active column count read as dead.
    assign up = upper_reg & en;
    assign md = middle_reg & en;
    assign cu = cur & en;

    // A one-row frame sees dead rows above and below.
    assign top_a = ctrl.single ? 1'b0 : up;
    assign mid_a = ctrl.single ? cu : md;
    assign bot_a = ctrl.single ? 1'b0 : cu;

    assign sums.sum_a = 2'(top_a) + 2'(mid_a) + 2'(bot_a);
    assign sums.sum_b = 2'(md) + 2'(cu);

    // The 3x3 total includes the center: birth at 3, survival at a total of 4.
    assign tot_a = 4'(left.sum_a) + 4'(sums.sum_a) + 4'(right.sum_a);
    assign tot_b = 4'(left.sum_b) + 4'(sums.sum_b) + 4'(right.sum_b);
    assign res_a = en & ((tot_a == 4'd3) | (mid_a & (tot_a == 4'd4)));
    assign res_b = en & ((tot_b == 4'd3) | (cu & (tot_b == 4'd4)));

    // Row window shift for the next transaction. An incoming bit is stored
    // already masked with the column count in force when it arrives.
    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (take)
        begin
            priority if (ctrl.clear)
            begin
                upper_next  = 1'b0;
                middle_next = 1'b0;
            end
            else if (ctrl.first)
            begin
                upper_next  = 1'b0;
                middle_next = cu;
            end
            else
            begin
                upper_next  = middle_reg;
                middle_next = cu;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg  <= upper_next;
        middle_reg <= middle_next;
    end

endmodule

### hw/rtl/lgrs_out_queue.sv
// Result queue of the Life row step unit: takes up to two results a cycle
// and presents one. Depends on lgrs_pkg.
module lgrs_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lgrs_pkg::queue_push_t  push,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lgrs_pkg::result_t      out_data
);
    import lgrs_pkg::*;

    result_t             q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[rptr_reg];
    assign pop       = out_valid & out_ready;
    assign space     = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wptr_next  = wptr_reg + QPTR_W'(push.a_valid) + QPTR_W'(push.b_valid);
        rptr_next  = rptr_reg + QPTR_W'(pop);
        count_next = count_reg + QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid)
                     - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage; the trailing result goes right after the main one.
    always_ff @(posedge clk)
    begin
        if (push.a_valid)
        begin
            q_reg[wptr_reg] <= push.a;
        end
        if (push.b_valid)
        begin
            q_reg[wptr_reg + QPTR_W'(1)] <= push.b;
        end
    end

endmodule

### hw/rtl/life_generation_row_step_unit.sv
// Top level of the Life row step unit: configuration, row counting, cell chain
// and result queue. Depends on lgrs_pkg, lgrs_cell and lgrs_out_queue.
//
// Takes one grid row per cycle on s_axis and returns the next B3/S23 generation
// of the row above it on m_axis; the accepting edge writes the results into the
// result queue. The row computation is a chain of MAX_COLUMNS cells working in
// parallel. The first row of a frame gives no result and the last row gives two,
// so a frame of R rows gives R results. A four-entry result queue decouples the
// sides: s_axis_tready is high while the queue has room for two results, so a
// stalled m_axis lets the unit keep taking rows until three or four results are
// queued. Configuration writes are accepted in every cycle and should be issued
// only while no result is pending.
module life_generation_row_step_unit #(
    parameter int MAX_COLUMNS = lgrs_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = lgrs_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Row input: tdata = row_cells[63:0].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lgrs_pkg::ROW_BITS-1:0]    s_axis_tdata,
    // Result output: tdata = next_row[63:0], row_index[73:64], zero pad;
    // tlast = last_of_frame.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lgrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lgrs_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [COLS_W-1:0]      column_count_reg;
    logic [ROWS_W-1:0]      row_count_reg;
    logic [ROW_W-1:0]       rows_seen_reg;
    logic [ROW_W-1:0]       rows_seen_next;
    logic [COLS_W-1:0]      eff_cols;
    logic [ROWS_W-1:0]      eff_rows;
    logic [ROWS_W-1:0]      seen_ext;
    logic                   take;
    logic                   last_row;
    cell_ctrl_t             ctrl;
    col_sums_t              sums [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] res_a_vec;
    logic [MAX_COLUMNS-1:0] res_b_vec;
    queue_push_t            push;
    logic                   q_space;
    result_t                out_item;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data[COLS_W-1:0];
            end
            else if (cfg_index == REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[ROWS_W-1:0];
            end
        end
    end

    // Counts clamped to their legal ranges.
    always_comb
    begin
        priority if (column_count_reg == '0)
            eff_cols = COLS_W'(1);
        else if (column_count_reg > COLS_W'(MAX_COLUMNS))
            eff_cols = COLS_W'(MAX_COLUMNS);
        else
            eff_cols = column_count_reg;

        priority if (row_count_reg == '0)
            eff_rows = ROWS_W'(1);
        else if (row_count_reg > ROWS_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = row_count_reg;
    end

    // Row position within the frame decides the kind of step.
    assign take        = s_axis_tvalid & s_axis_tready;
    assign seen_ext    = ROWS_W'(rows_seen_reg);
    assign ctrl.single = (eff_rows == ROWS_W'(1));
    assign ctrl.first  = !ctrl.single && (rows_seen_reg == '0);
    assign last_row    = !ctrl.single && !ctrl.first
                         && ((seen_ext + ROWS_W'(1)) >= eff_rows);
    assign ctrl.clear  = ctrl.single | last_row;

    always_comb
    begin
        rows_seen_next = rows_seen_reg;
        if (take)
        begin
            if (ctrl.clear)
                rows_seen_next = '0;
            else
                rows_seen_next = rows_seen_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_seen_reg <= '0;
        else
            rows_seen_reg <= rows_seen_next;
    end

    // Chain of column cells; each reads its neighbors' vertical counts.
    for (genvar j = 0; j < MAX_COLUMNS; j++)
    begin : g_cell
        col_sums_t left_s;
        col_sums_t right_s;
        logic      en;

        assign en = (COLS_W'(j) < eff_cols);

        if (j == 0)
        begin : g_left_edge
            assign left_s = '0;
        end
        else
        begin : g_left_cell
            assign left_s = sums[j-1];
        end

        if (j == MAX_COLUMNS - 1)
        begin : g_right_edge
            assign right_s = '0;
        end
        else
        begin : g_right_cell
            assign right_s = sums[j+1];
        end

        lgrs_cell u_cell (
            .clk   (clk),
            .en    (en),
            .take  (take),
            .ctrl  (ctrl),
            .cur   (s_axis_tdata[j]),
            .left  (left_s),
            .right (right_s),
            .sums  (sums[j]),
            .res_a (res_a_vec[j]),
            .res_b (res_b_vec[j])
        );
    end

    // Results of this row into the queue.
    always_comb
    begin
        push.a_valid         = take & !ctrl.first;
        push.b_valid         = take & last_row;
        push.a.next_row      = ROW_BITS'(res_a_vec);
        push.a.row_index     = ctrl.single ? '0 : IDX_BITS'(rows_seen_reg - ROW_W'(1));
        push.a.last_of_frame = ctrl.single;
        push.b.next_row      = ROW_BITS'(res_b_vec);
        push.b.row_index     = IDX_BITS'(rows_seen_reg);
        push.b.last_of_frame = 1'b1;
    end

    lgrs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (q_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item)
    );

    assign s_axis_tready = q_space;
    assign m_axis_tdata  = {(OUT_TDATA_W - ROW_BITS - IDX_BITS)'(0),
                            out_item.row_index, out_item.next_row};
    assign m_axis_tlast  = out_item.last_of_frame;

endmodule

### hw/rtl/lgrs_checker.sv
// Port-level checker for the Life row step unit, bound to its top level.
// Depends on lgrs_pkg and life_generation_row_step_unit_defines.svh.
`include "life_generation_row_step_unit_defines.svh"

module lgrs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lgrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);
    import lgrs_pkg::*;

    logic                out_xfer;
    logic [IDX_BITS-1:0] out_index;

    assign out_xfer  = m_axis_tvalid & m_axis_tready;
    assign out_index = m_axis_tdata[ROW_BITS+IDX_BITS-1:ROW_BITS];

    // A stalled result keeps its contents.
    `LGRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result changed")

    // With nothing queued there is always room for another row.
    `LGRS_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready,
        "input stalled while the result queue is empty")

    // Back-to-back results count up within a frame and restart after its end.
    `LGRS_ASSERT_NOW(a_index_seq, out_xfer && $past(out_xfer) && $past(m_axis_tlast),
        out_index == '0, "new frame does not start at row zero")
    `LGRS_ASSERT_NOW(a_index_step, out_xfer && $past(out_xfer) && !$past(m_axis_tlast),
        out_index == ($past(out_index) + 10'd1), "row index skipped within a frame")

endmodule

bind life_generation_row_step_unit lgrs_checker u_lgrs_checker (.*);
